// ----- src/sedf_pkg.sv -----
package sedf_pkg;

   localparam logic [7:0] BYTE_STX        = 8'h02;
   localparam logic [7:0] BYTE_ETX        = 8'h03;
   localparam logic [7:0] BYTE_NAK        = 8'h15;
   localparam logic [7:0] EXT_COMMAND_MIN = 8'h80;

   // parser phase, one-hot
   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_COMMAND = 7'b0000010,
      PH_LENGTH  = 7'b0000100,
      PH_PAYLOAD = 7'b0001000,
      PH_CRC_HI  = 7'b0010000,
      PH_CRC_LO  = 7'b0100000,
      PH_TERM    = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_COMMAND = 3'd0,
      ROLE_LENGTH  = 3'd1,
      ROLE_PAYLOAD = 3'd2,
      ROLE_CRC_HI  = 3'd3,
      ROLE_CRC_LO  = 3'd4,
      ROLE_TERM    = 3'd5
   } role_type;

   typedef enum logic [1:0] {
      ST_GOOD   = 2'd0,
      ST_NAK    = 2'd1,
      ST_LEGACY = 2'd2,
      ST_BADEND = 2'd3
   } status_type;

   // one tagged frame word
   typedef struct packed {
      logic [7:0] frame_byte;
      role_type   byte_role;
      status_type frame_status;
      logic       frame_last;
   } result_type;

endpackage

// ----- src/sedf_in_stage.sv -----
module sedf_in_stage import sedf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   output logic       held_valid,
   input  logic       held_take,
   output logic [7:0] held_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign in_ready   = !valid_ff || held_take;
   assign valid_in   = (in_valid && in_ready) ? 1'b1 : (held_take ? 1'b0 : valid_ff);
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

endmodule

// ----- src/sedf_parser.sv -----
module sedf_parser import sedf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,       // consume one byte this cycle
   input  logic [7:0] rx_byte,
   output logic       emit,
   output result_type result
);

   phase_type  phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] held_command_ff, held_command_in;
   logic [7:0] left_dec;

   assign left_dec = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in            = phase_ff;
      bytes_left_in       = bytes_left_ff;
      held_command_in     = held_command_ff;
      emit                = 1'b0;
      result.frame_byte   = rx_byte;
      result.byte_role    = ROLE_COMMAND;
      result.frame_status = ST_GOOD;
      result.frame_last   = 1'b0;
      case (phase_ff)
         PH_COMMAND: begin
            if (rx_byte != BYTE_STX) begin
               held_command_in = rx_byte;
               phase_in        = PH_LENGTH;
               emit            = 1'b1;
            end
         end
         PH_LENGTH: begin
            bytes_left_in    = rx_byte;
            phase_in         = (rx_byte == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
            emit             = 1'b1;
            result.byte_role = ROLE_LENGTH;
         end
         PH_PAYLOAD: begin
            bytes_left_in    = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_CRC_HI;
            end
            emit             = 1'b1;
            result.byte_role = ROLE_PAYLOAD;
         end
         PH_CRC_HI: begin
            phase_in         = PH_CRC_LO;
            emit             = 1'b1;
            result.byte_role = ROLE_CRC_HI;
         end
         PH_CRC_LO: begin
            phase_in         = PH_TERM;
            emit             = 1'b1;
            result.byte_role = ROLE_CRC_LO;
         end
         PH_TERM: begin
            if (rx_byte == BYTE_NAK) begin
               result.frame_status = ST_NAK;
            end else if (rx_byte == BYTE_ETX) begin
               result.frame_status = (held_command_ff < EXT_COMMAND_MIN) ? ST_LEGACY : ST_GOOD;
            end else begin
               result.frame_status = ST_BADEND;
            end
            phase_in          = PH_HUNT;
            bytes_left_in     = 8'd0;
            emit              = 1'b1;
            result.byte_role  = ROLE_TERM;
            result.frame_last = 1'b1;
         end
         default: begin
            // hunting: drop everything up to a start byte
            phase_in = (rx_byte == BYTE_STX) ? PH_COMMAND : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         bytes_left_ff   <= 8'd0;
         held_command_ff <= 8'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         held_command_ff <= held_command_in;
      end
   end

endmodule

// ----- src/stx_etx_frame_deframer_core.sv -----
// STX/ETX deframer: splits a received byte stream into tagged frame words.
// Each accepted byte passes the input register, then the result register, before it can raise rsp_tvalid.
// Throughput: one byte per cycle, sustained, while rsp_tready stays high.
// Dropped bytes (hunting, repeated STX) still take one slot in the input register.
// Reset (synchronous, active high): both stages empty, parser back to hunting for STX.
module stx_etx_frame_deframer_core import sedf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // received bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   // tagged frame words
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_byte
   output logic [4:0] rsp_tuser,   // [2:0] byte_role, [4:3] frame_status
   output logic       rsp_tlast    // frame_last: terminator word
);

   logic       held_valid;
   logic [7:0] held_byte;
   logic       out_free;
   logic       step;
   logic       emit;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // The result register can take a new word when it is empty or being drained.
   // The parser advances exactly when it takes the held byte, which needs the result register free.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign step     = held_valid && out_free;

   sedf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .held_valid (held_valid),
      .held_take  (step),
      .held_byte  (held_byte)
   );

   sedf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (held_byte),
      .emit    (emit),
      .result  (result)
   );

   // Bytes that produce nothing simply leave the result register empty.
   assign rsp_valid_in = out_free ? (step && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.frame_byte;
   assign rsp_tuser  = {rsp_ff.frame_status, rsp_ff.byte_role};
   assign rsp_tlast  = rsp_ff.frame_last;

endmodule
